// File: hdl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg : shared types and tables for the day count to date converter
// Holds the sequencer step codes, the control word and its program table,
// and the small calendar helpers used by the datapath.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam logic [15:0] OFFSET_RESET = 16'd5000;
	localparam logic [11:0] BASE_YEAR    = 12'd2000;
	localparam logic [2:0]  BASE_WDAY    = 3'd6;
	localparam logic [3:0]  LAST_MONTH   = 4'd12;

	typedef enum logic [1:0] {
		PC_WAIT,
		PC_MONTH,
		PC_EMIT
	} pc_t;

	typedef enum logic [1:0] {
		COND_IN_ACC,
		COND_REST_LT,
		COND_OUT_FREE
	} cond_t;

	// load and emit fire when the condition holds, step fires while it fails
	typedef struct packed {
		logic  load;
		logic  step;
		logic  emit;
		cond_t cond;
		pc_t   go_hit;
		pc_t   go_miss;
	} ctl_t;

	function automatic ctl_t rom_word(input pc_t pc);
		ctl_t w;
		w = '0;
		unique case (pc)
			PC_WAIT: begin
				w.load    = 1'b1;
				w.cond    = COND_IN_ACC;
				w.go_hit  = PC_MONTH;
				w.go_miss = PC_WAIT;
			end
			PC_MONTH: begin
				w.step    = 1'b1;
				w.cond    = COND_REST_LT;
				w.go_hit  = PC_EMIT;
				w.go_miss = PC_MONTH;
			end
			PC_EMIT: begin
				w.emit    = 1'b1;
				w.cond    = COND_OUT_FREE;
				w.go_hit  = PC_WAIT;
				w.go_miss = PC_EMIT;
			end
			default: begin
				w.cond    = COND_IN_ACC;
				w.go_hit  = PC_WAIT;
				w.go_miss = PC_WAIT;
			end
		endcase
		return w;
	endfunction

	// every year divisible by four is leap, century years included
	function automatic logic [4:0] month_length(input logic [3:0] month,
		input logic [11:0] year);
		logic [4:0] len;
		case (month)
			4'd2:                               len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:            len = 5'd30;
			default:                            len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] mod7(input logic [4:0] v);
		logic [4:0] r;
		if (v >= 5'd28)
			r = v - 5'd28;
		else if (v >= 5'd21)
			r = v - 5'd21;
		else if (v >= 5'd14)
			r = v - 5'd14;
		else if (v >= 5'd7)
			r = v - 5'd7;
		else
			r = v;
		return r[2:0];
	endfunction

endpackage

// File: hdl/day_count_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_core : day index to calendar date converter
// Adds the configured offset to a day index, counts off whole months from
// 1 January 2000 under a small microprogram and returns date and weekday.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  day_index
//  out      out_valid/ out_stall day_of_month, month_number, year_number, weekday
//  cfg      cfg_valid/ cfg_ready cfg_data (date_offset)
//
// The month step counts off one month a cycle, up to about 2150 whole months
// in the offset sum. The next beat is taken only once the sequencer is back
// at its wait step, after the emit step has passed the result on, so an item
// holds the sequencer until then. Reset sets date_offset to 5000 and parks the
// sequencer at its wait step. A stalled result holds in the output register;
// the next item is taken meanwhile, and its own result waits at the emit step
// until the register frees.
module day_count_to_calendar_date_core import dcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] day_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_number,
	output logic [11:0] year_number,
	output logic [2:0]  weekday,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	pc_t         pc_q;
	pc_t         pc_nx;
	ctl_t        ctl;
	logic        hit;
	logic [15:0] offset_q;
	logic [15:0] rest_q;
	logic [3:0]  month_q;
	logic [11:0] year_q;
	logic [2:0]  wday_q;
	logic [4:0]  len;
	logic [3:0]  wday_add;
	logic [3:0]  wday_fin;
	logic        out_valid_q;
	logic        out_free;

	assign ctl       = rom_word(pc_q);
	assign cfg_ready = 1'b1;
	assign in_stall  = !ctl.load;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign len       = month_length(month_q, year_q);

	always_comb begin
		case (ctl.cond)
			COND_IN_ACC:   hit = in_valid;
			COND_REST_LT:  hit = rest_q < {11'd0, len};
			COND_OUT_FREE: hit = out_free;
			default:       hit = 1'b0;
		endcase
	end

	always_comb begin
		pc_nx = hit ? ctl.go_hit : ctl.go_miss;
	end

	// weekday advances by the month length modulo seven
	always_comb begin
		wday_add = {1'b0, wday_q} + {2'b00, 2'(len - 5'd28)};
		if (wday_add >= 4'd7)
			wday_add = wday_add - 4'd7;
		wday_fin = {1'b0, wday_q} + {1'b0, mod7(rest_q[4:0])};
		if (wday_fin >= 4'd7)
			wday_fin = wday_fin - 4'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			offset_q    <= OFFSET_RESET;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_nx;
			if (cfg_valid && cfg_ready)
				offset_q <= cfg_data;
			if (ctl.emit && hit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && hit) begin
			rest_q  <= day_index + offset_q;
			month_q <= 4'd1;
			year_q  <= BASE_YEAR;
			wday_q  <= BASE_WDAY;
		end
		if (ctl.step && !hit) begin
			rest_q <= rest_q - {11'd0, len};
			wday_q <= wday_add[2:0];
			if (month_q == LAST_MONTH) begin
				month_q <= 4'd1;
				year_q  <= year_q + 12'd1;
			end else begin
				month_q <= month_q + 4'd1;
			end
		end
		if (ctl.emit && hit) begin
			day_of_month <= rest_q[4:0] + 5'd1;
			month_number <= month_q;
			year_number  <= year_q;
			weekday      <= wday_fin[2:0];
		end
	end

`ifndef SYNTH
	a_load_starts_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == PC_MONTH)
		else $error("accepted beat did not start the month count");
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pc_q) == PC_EMIT)
		else $error("result raised outside the emit step");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_MONTH |-> month_q >= 4'd1 && month_q <= LAST_MONTH)
		else $error("month out of range during count");
	a_rest_fits: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_EMIT |-> rest_q < 16'd31)
		else $error("remaining days exceed a month at emit");
`endif

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench : day count to calendar date converter
// Drives day indexes under several offsets, predicts each date and weekday
// with a month-by-month count of its own and checks every result beat in
// order, with random input bursts, random output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import dcc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int      HOLD_CYCLES = 3000;
	localparam int      SETTLE      = 8;
	localparam longint  CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		logic [4:0]  dom;
		logic [3:0]  mon;
		logic [11:0] yr;
		logic [2:0]  wd;
	} date_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] day_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [11:0] year_number;
	logic [2:0]  weekday;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	date_t       expected_dates[$];
	logic [15:0] cur_offset = OFFSET_RESET;
	int          mismatches = 0;
	int          burst_left = 0;
	longint      cycles = 0;

	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          pat_count = 0;
	int          stall_mode = 0;

	day_count_to_calendar_date_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.day_index    (day_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.day_of_month (day_of_month),
		.month_number (month_number),
		.year_number  (year_number),
		.weekday      (weekday),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// count off whole months from 1 Jan 2000; every fourth year is leap
	function automatic date_t date_from_days(input logic [15:0] idx,
		input logic [15:0] ofs);
		logic [15:0] days;
		int unsigned left;
		int unsigned mon;
		int unsigned yr;
		int unsigned mlen;
		date_t d;
		days = idx + ofs;
		left = 32'(days);
		mon = 1;
		yr = 32'(BASE_YEAR);
		forever begin
			case (mon)
				2:           mlen = (yr % 4 == 0) ? 29 : 28;
				4, 6, 9, 11: mlen = 30;
				default:     mlen = 31;
			endcase
			if (left < mlen)
				break;
			left -= mlen;
			mon++;
			if (mon > LAST_MONTH) begin
				mon = 1;
				yr++;
			end
		end
		d.dom = 5'(left + 1);
		d.mon = 4'(mon);
		d.yr  = 12'(yr);
		d.wd  = 3'((32'(BASE_WDAY) + 32'(days)) % 7);
		return d;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: long hold-off on request, otherwise a stall pattern per segment
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (pat_count == 0) begin
				stall_mode <= $urandom_range(0, 2);
				pat_count <= $urandom_range(10, 80);
			end else
				pat_count <= pat_count - 1;
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 7) == 0);
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		date_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_dates.size() == 0) begin
				$error("result beat with nothing expected: %0d-%0d-%0d wd %0d",
					year_number, month_number, day_of_month, weekday);
				mismatches++;
			end else begin
				want = expected_dates.pop_front();
				if (day_of_month !== want.dom) begin
					$error("day_of_month: expected %0d, got %0d", want.dom, day_of_month);
					mismatches++;
				end
				if (month_number !== want.mon) begin
					$error("month_number: expected %0d, got %0d", want.mon, month_number);
					mismatches++;
				end
				if (year_number !== want.yr) begin
					$error("year_number: expected %0d, got %0d", want.yr, year_number);
					mismatches++;
				end
				if (weekday !== want.wd) begin
					$error("weekday: expected %0d, got %0d", want.wd, weekday);
					mismatches++;
				end
			end
		end
	end

	task automatic send_day(input logic [15:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		day_index <= idx;
		do @(posedge clk); while (in_stall);
		expected_dates.push_back(date_from_days(idx, cur_offset));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_offset(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_offset = value;
	endtask

	// offset left at its reset value, including a sum that wraps to zero
	task automatic test_reset_offset();
		send_day(16'd0);
		send_day(16'd65535);
		send_day(16'd60536);
		drain_results();
	endtask

	// month ends, leap days, year turns and the 2100 leap day
	task automatic test_calendar_edges();
		logic [15:0] days[$];
		days = '{16'd0, 16'd30, 16'd31, 16'd58, 16'd59, 16'd60, 16'd365,
			16'd366, 16'd1460, 16'd36583, 16'd36584, 16'd36585, 16'd65535,
			16'hAAAA, 16'h5555};
		write_offset(16'd0);
		foreach (days[i])
			send_day(days[i]);
		drain_results();
	endtask

	task automatic test_offset_wrap();
		write_offset(16'hFFFF);
		send_day(16'd1);
		send_day(16'd0);
		send_day(16'hFFFF);
		drain_results();
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		write_offset(16'd0);
		hold_requests <= hold_requests + 1;
		repeat (8)
			send_day(16'($urandom_range(0, 200)));
		drain_results();
	endtask

	task automatic test_random_days();
		for (int phase = 0; phase < 5; phase++) begin
			write_offset((phase == 1) ? 16'd0 : 16'($urandom_range(0, 65535)));
			for (int n = 0; n < 48; n++) begin
				if ($urandom_range(0, 3) == 0)
					send_day(16'($urandom_range(0, 1500)));
				else
					send_day(16'($urandom_range(0, 65535)));
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_offset();
		test_calendar_edges();
		test_offset_wrap();
		test_backpressure();
		test_random_days();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
hdl/dcc_pkg.sv
hdl/day_count_to_calendar_date_core.sv
dv/testbench.sv
